// ===== sv/sha1h_pkg.sv =====
// Shared types, constants and round functions for the SHA-1 stream hasher.
package sha1h_pkg;

    localparam int unsigned NumChain  = 5;
    localparam int unsigned NumSched  = 16;
    localparam int unsigned NumRounds = 80;
    localparam int unsigned BlockBits = 512;

    typedef logic [31:0] word_t;

    localparam word_t ChainInit [NumChain] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [7:0] PadMark = 8'h80;

    typedef enum logic [1:0] {
        BYTE_DATA,
        BYTE_PAD80,
        BYTE_ZERO,
        BYTE_LEN
    } byte_sel_t;

    // Controller to datapath command word.
    typedef struct packed {
        logic       shift_en;
        byte_sel_t  byte_sel;
        logic [2:0] len_idx;
        logic       count_en;
        logic       comp_load;
        logic       round_en;
        logic [1:0] round_grp;
        logic       chain_add;
        logic       msg_init;
        logic       out_load;
        logic [2:0] out_idx;
    } dp_cmd_t;

    function automatic word_t round_const(input logic [1:0] grp);
        word_t k;
        case (grp)
            2'd0:    k = 32'h5A827999;
            2'd1:    k = 32'h6ED9EBA1;
            2'd2:    k = 32'h8F1BBCDC;
            default: k = 32'hCA62C1D6;
        endcase
        return k;
    endfunction

    function automatic word_t round_func(input logic [1:0] grp, input word_t b,
                                        input word_t c, input word_t d);
        word_t f;
        case (grp)
            2'd0:    f = (b & c) | (~b & d);
            2'd2:    f = (b & c) | (b & d) | (c & d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

// ===== sv/sha1h_datapath.sv =====
// Datapath: block shift buffer, message schedule, round registers, chaining words, output word.
module sha1h_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1h_pkg::dp_cmd_t  cmd,
    input  logic [7:0]          data_byte,
    output logic [31:0]         digest_word,
    output logic [2:0]          word_index,
    output logic                last_word
);
    import sha1h_pkg::*;

    logic [BlockBits-1:0] blk_reg;
    logic [BlockBits-1:0] blk_next;
    word_t                sched_reg [NumSched];
    word_t                work_reg  [NumChain];
    word_t                chain_reg [NumChain];
    logic [63:0]          msg_reg;
    word_t                word_reg;
    logic [2:0]           idx_reg;
    logic                 last_reg;

    logic [7:0]           byte_mux;
    logic [63:0]          bit_len;
    logic [2:0]           len_shift;
    word_t                sched_new;
    word_t                round_sum;

    assign bit_len   = {msg_reg[60:0], 3'b000};
    assign len_shift = 3'd7 - cmd.len_idx;

    always_comb
    begin
        case (cmd.byte_sel)
            BYTE_DATA:  byte_mux = data_byte;
            BYTE_PAD80: byte_mux = PadMark;
            BYTE_LEN:   byte_mux = bit_len[{len_shift, 3'b000} +: 8];
            default:    byte_mux = 8'h00;
        endcase
    end

    assign blk_next  = {blk_reg[BlockBits-9:0], byte_mux};

    // W[t+16] from the taps of the sliding window
    assign sched_new = {sched_reg[13][30:0] ^ sched_reg[8][30:0] ^
                        sched_reg[2][30:0] ^ sched_reg[0][30:0],
                        sched_reg[13][31] ^ sched_reg[8][31] ^
                        sched_reg[2][31] ^ sched_reg[0][31]};

    assign round_sum = {work_reg[0][26:0], work_reg[0][31:27]}
                     + round_func(cmd.round_grp, work_reg[1], work_reg[2], work_reg[3])
                     + work_reg[4] + round_const(cmd.round_grp) + sched_reg[0];

    always_ff @(posedge clk)
    begin
        if (cmd.shift_en)
        begin
            blk_reg <= blk_next;
        end
        if (cmd.comp_load)
        begin
            for (int i = 0; i < NumSched; i++)
            begin
                sched_reg[i] <= blk_next[BlockBits-1-32*i -: 32];
            end
            for (int i = 0; i < NumChain; i++)
            begin
                work_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.round_en)
        begin
            for (int i = 0; i < NumSched - 1; i++)
            begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[NumSched-1] <= sched_new;
            work_reg[4] <= work_reg[3];
            work_reg[3] <= work_reg[2];
            work_reg[2] <= {work_reg[1][1:0], work_reg[1][31:2]};
            work_reg[1] <= work_reg[0];
            work_reg[0] <= round_sum;
        end
        if (cmd.out_load)
        begin
            word_reg <= chain_reg[cmd.out_idx];
            idx_reg  <= cmd.out_idx;
            last_reg <= (cmd.out_idx == 3'(NumChain - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumChain; i++)
            begin
                chain_reg[i] <= ChainInit[i];
            end
            msg_reg <= '0;
        end
        else
        begin
            if (cmd.msg_init)
            begin
                for (int i = 0; i < NumChain; i++)
                begin
                    chain_reg[i] <= ChainInit[i];
                end
                msg_reg <= '0;
            end
            else
            begin
                if (cmd.chain_add)
                begin
                    for (int i = 0; i < NumChain; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + work_reg[i];
                    end
                end
                if (cmd.count_en)
                begin
                    msg_reg <= msg_reg + 64'd1;
                end
            end
        end
    end

    assign digest_word = word_reg;
    assign word_index  = idx_reg;
    assign last_word   = last_reg;

endmodule

// ===== sv/sha1h_ctrl.sv =====
// Controller: absorb/pad/emit sequencer and the 80-round compression counter.
module sha1h_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_cmd,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output sha1h_pkg::dp_cmd_t  cmd
);
    import sha1h_pkg::*;

    typedef enum logic [1:0] {
        ST_ABSORB,
        ST_PAD,
        ST_WAIT,
        ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] fill_reg, fill_next;
    logic       first_reg, first_next;
    logic       len_ok_reg, len_ok_next;
    logic       busy_reg, busy_next;
    logic [6:0] rnd_reg, rnd_next;
    logic [2:0] emit_reg, emit_next;
    logic       out_valid_reg, out_valid_next;

    logic       block_end;
    logic       can_shift;

    assign block_end = (fill_reg == 6'd63);
    assign can_shift = !(block_end && busy_reg);
    assign in_ready  = (state_reg == ST_ABSORB) && can_shift;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        first_next     = first_reg;
        len_ok_next    = len_ok_reg;
        busy_next      = busy_reg;
        rnd_next       = rnd_reg;
        emit_next      = emit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.byte_sel   = BYTE_DATA;
        cmd.len_idx    = fill_reg[2:0];
        cmd.out_idx    = emit_reg;

        // compression engine: 80 rounds, then fold into the chaining words
        if (busy_reg)
        begin
            if (rnd_reg == 7'(NumRounds))
            begin
                cmd.chain_add = 1'b1;
                busy_next     = 1'b0;
            end
            else
            begin
                cmd.round_en = 1'b1;
                rnd_next     = rnd_reg + 7'd1;
            end
        end
        if (rnd_reg < 7'd20)
        begin
            cmd.round_grp = 2'd0;
        end
        else if (rnd_reg < 7'd40)
        begin
            cmd.round_grp = 2'd1;
        end
        else if (rnd_reg < 7'd60)
        begin
            cmd.round_grp = 2'd2;
        end
        else
        begin
            cmd.round_grp = 2'd3;
        end

        case (state_reg)
            ST_ABSORB:
            begin
                if (in_valid && in_ready)
                begin
                    if (!in_cmd)
                    begin
                        cmd.shift_en = 1'b1;
                        cmd.count_en = 1'b1;
                        fill_next    = fill_reg + 6'd1;
                        if (block_end)
                        begin
                            cmd.comp_load = 1'b1;
                            busy_next     = 1'b1;
                            rnd_next      = '0;
                        end
                    end
                    else
                    begin
                        state_next  = ST_PAD;
                        first_next  = 1'b1;
                        len_ok_next = 1'b0;
                    end
                end
            end
            ST_PAD:
            begin
                if (can_shift)
                begin
                    cmd.shift_en = 1'b1;
                    fill_next    = fill_reg + 6'd1;
                    first_next   = 1'b0;
                    if (first_reg)
                    begin
                        cmd.byte_sel = BYTE_PAD80;
                        if (fill_reg < 6'd56)
                        begin
                            len_ok_next = 1'b1;
                        end
                    end
                    else if (len_ok_reg && fill_reg >= 6'd56)
                    begin
                        cmd.byte_sel = BYTE_LEN;
                    end
                    else
                    begin
                        cmd.byte_sel = BYTE_ZERO;
                    end
                    if (block_end)
                    begin
                        cmd.comp_load = 1'b1;
                        busy_next     = 1'b1;
                        rnd_next      = '0;
                        if (len_ok_reg)
                        begin
                            state_next = ST_WAIT;
                        end
                        else
                        begin
                            len_ok_next = 1'b1;
                        end
                    end
                end
            end
            ST_WAIT:
            begin
                if (!busy_reg)
                begin
                    state_next = ST_EMIT;
                    emit_next  = '0;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    emit_next      = emit_reg + 3'd1;
                    if (emit_reg == 3'(NumChain - 1))
                    begin
                        cmd.msg_init = 1'b1;
                        state_next   = ST_ABSORB;
                    end
                end
            end
            default:
            begin
                state_next = ST_ABSORB;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ABSORB;
            fill_reg      <= '0;
            first_reg     <= 1'b0;
            len_ok_reg    <= 1'b0;
            busy_reg      <= 1'b0;
            rnd_reg       <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            first_reg     <= first_next;
            len_ok_reg    <= len_ok_next;
            busy_reg      <= busy_next;
            rnd_reg       <= rnd_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/sha1_stream_hasher.sv =====
// Top level of the SHA-1 stream hasher: stream ports, controller and datapath.
// One byte word per cycle while absorbing; the 64th byte of a block starts a compression
// (80 rounds plus the chaining add) beside intake, and the next block's 64th byte waits
// for it. After the end-of-message word the block is padded, the length spilling into a
// second block if it does not fit; after the last compression the digest follows, one
// word per cycle while the receiver is ready. Async reset loads the initial chain.
module sha1_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] cmd: 0 absorb byte, 1 end of message
    // digest stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        m_axis_tlast    // last_word
);
    import sha1h_pkg::*;

    dp_cmd_t     dp_cmd;
    logic [31:0] digest_word;
    logic [2:0]  word_index;

    // Sequencer: accepts words, drives padding, counts rounds and paces the digest
    sha1h_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_cmd    (s_axis_tuser[0]),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (dp_cmd)
    );

    // Block buffer, schedule window, round registers and the held output word
    sha1h_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (dp_cmd),
        .data_byte   (s_axis_tdata),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (m_axis_tlast)
    );

    // Pack the result word: digest in the low bits, index above it
    assign m_axis_tdata = {5'b00000, word_index, digest_word};

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the SHA-1 stream hasher: byte words in, digest words out.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic       CMD_ABSORB   = 1'b0;
    localparam logic       CMD_FINISH   = 1'b1;
    localparam logic [7:0] PAD_BYTE     = 8'h80;
    localparam int         LAST_INDEX   = 4;
    // No word in either direction for this many cycles means the block hung.
    // Worst legal quiet stretch is the forced output hold plus a padded
    // two-block finish, well under this.
    localparam int         IDLE_LIMIT   = 3000;
    // Trailing pad bytes plus up to two compressions, each of 80 rounds and the chaining add.
    localparam int         DRAIN_CYCLES = 250;
    localparam int         HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_entry_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic [0:0]  s_axis_tuser = 1'b0;    // [0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // [31:0] digest_word, [34:32] word_index
    logic        m_axis_tlast;           // last_word

    // Predictor state: running hash, pending block bytes and message length.
    logic [31:0]   hash_state [5];
    logic [7:0]    block_buf [64];
    int unsigned   block_fill;
    logic [63:0]   msg_len;
    digest_entry_t digest_q [$];

    int err_count     = 0;
    int idle_cycles   = 0;
    int items_sent    = 0;
    int hold_requests = 0;
    int burst_left    = 0;
    bit pace_on       = 1'b1;

    sha1_stream_hasher u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Hash predictor
    // ------------------------------------------------------------------

    // Back to the initial chaining values with an empty block.
    function automatic void restart_message();
        hash_state[0] = 32'h67452301;
        hash_state[1] = 32'hEFCDAB89;
        hash_state[2] = 32'h98BADCFE;
        hash_state[3] = 32'h10325476;
        hash_state[4] = 32'hC3D2E1F0;
        block_fill    = 0;
        msg_len       = 64'd0;
    endfunction

    // Fold the 64 buffered bytes into the running hash, 80 rounds.
    function automatic void compress_block();
        logic [31:0] sched [16];
        logic [31:0] a, b, c, d, e, f, k, mix, t_sum;
        int          t;
        for (t = 0; t < 16; t++)
            sched[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (t = 0; t < 80; t++)
        begin
            if (t >= 16)
            begin
                mix = sched[(t - 3) & 15] ^ sched[(t - 8) & 15] ^ sched[(t - 14) & 15]
                    ^ sched[t & 15];
                sched[t & 15] = {mix[30:0], mix[31]};
            end
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t_sum = {a[26:0], a[31:27]} + f + e + k + sched[t & 15];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t_sum;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted input word, check each output word
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_and_predict
        digest_entry_t want;
        logic [63:0]   bit_len;
        int            i;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (digest_q.size() == 0)
                begin
                    $error("unexpected digest word %h", m_axis_tdata[31:0]);
                    err_count++;
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (m_axis_tdata[31:0] !== want.digest_word)
                    begin
                        $error("digest_word: expected %h, got %h",
                               want.digest_word, m_axis_tdata[31:0]);
                        err_count++;
                    end
                    if (m_axis_tdata[34:32] !== want.word_index)
                    begin
                        $error("word_index: expected %0d, got %0d",
                               want.word_index, m_axis_tdata[34:32]);
                        err_count++;
                    end
                    if (m_axis_tlast !== want.last_word)
                    begin
                        $error("last_word: expected %0b, got %0b", want.last_word, m_axis_tlast);
                        err_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser[0] == CMD_ABSORB)
                begin
                    block_buf[block_fill] = s_axis_tdata;
                    block_fill++;
                    msg_len++;
                    if (block_fill == 64)
                    begin
                        compress_block();
                        block_fill = 0;
                    end
                end
                else
                begin
                    // Pad: marker byte, zeros, then the bit length big-endian.
                    // A marker landing past byte 55 pushes the length into a
                    // second block.
                    bit_len = msg_len << 3;
                    block_buf[block_fill] = PAD_BYTE;
                    block_fill++;
                    if (block_fill > 56)
                    begin
                        while (block_fill < 64)
                        begin
                            block_buf[block_fill] = 8'h00;
                            block_fill++;
                        end
                        compress_block();
                        block_fill = 0;
                    end
                    while (block_fill < 56)
                    begin
                        block_buf[block_fill] = 8'h00;
                        block_fill++;
                    end
                    for (i = 0; i < 8; i++)
                        block_buf[56 + i] = bit_len[63 - 8*i -: 8];
                    compress_block();
                    for (i = 0; i <= LAST_INDEX; i++)
                    begin
                        want.digest_word = hash_state[i];
                        want.word_index  = 3'(i);
                        want.last_word   = (i == LAST_INDEX);
                        digest_q = {digest_q, want};
                    end
                    restart_message();
                end
            end
        end
    end

    // Hang detector: count cycles with no word moving on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern of its own, plus long holds on request
    // ------------------------------------------------------------------
    initial
    begin : digest_sink
        int hold_served;
        int hold_left;
        int mode;
        int mode_left;
        int phase;
        hold_served = 0;
        hold_left   = 0;
        mode        = 0;
        mode_left   = 0;
        phase       = 0;
        forever
        begin
            @(negedge clk);
            phase++;
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                // Hold off so the output side backs up into the input.
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 120);
                end
                mode_left--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= (phase % 5) >= 2;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one word; entered and left at a falling edge, tvalid left high.
    task automatic send_word(input logic cmd, input logic [7:0] data);
        int gap;
        gap = 0;
        if (pace_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(1, 10);
            end
            burst_left--;
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Random bytes of the given length, then the finish word.
    task automatic send_message(input int len);
        int i;
        for (i = 0; i < len; i++)
            send_word(CMD_ABSORB, 8'($urandom_range(0, 255)));
        send_word(CMD_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty messages back to back; the data byte on a finish is ignored.
    task automatic test_empty_message();
        send_word(CMD_FINISH, 8'hFF);
        send_word(CMD_FINISH, 8'h00);
    endtask

    // Known short messages, byte extremes and a lone marker-valued byte.
    task automatic test_short_messages();
        send_word(CMD_ABSORB, 8'h61);
        send_word(CMD_ABSORB, 8'h62);
        send_word(CMD_ABSORB, 8'h63);
        send_word(CMD_FINISH, 8'h00);
        send_word(CMD_ABSORB, 8'h00);
        send_word(CMD_ABSORB, 8'hFF);
        send_word(CMD_FINISH, 8'hFF);
        send_word(CMD_ABSORB, PAD_BYTE);
        send_word(CMD_FINISH, 8'h00);
    endtask

    // Lengths around the point where the length field no longer fits.
    task automatic test_pad_boundary();
        pace_on = 1'b0;
        send_message(55);
        pace_on = 1'b1;
        send_message($urandom_range(56, 63));
    endtask

    // Stall the digest side for a long stretch while short messages pour in.
    task automatic test_output_backpressure();
        hold_requests++;
        pace_on = 1'b0;
        repeat (4) send_message($urandom_range(0, 4));
        pace_on = 1'b1;
    endtask

    // One message that crosses a full data block, then short random ones.
    task automatic test_random_messages();
        int start;
        start = items_sent;
        send_message($urandom_range(64, 70));
        while (items_sent - start < 80)
            send_message($urandom_range(0, 12));
    endtask

    initial
    begin
        restart_message();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_message();
        test_short_messages();
        test_pad_boundary();
        test_output_backpressure();
        test_random_messages();

        s_axis_tvalid <= 1'b0;
        while (digest_q.size() != 0)
            @(posedge clk);
        // Let any stray output show up before calling it done.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== sha1_stream_hasher.f =====
sv/sha1h_pkg.sv
sv/sha1h_datapath.sv
sv/sha1h_ctrl.sv
sv/sha1_stream_hasher.sv
dv/tb_top.sv
